>>> design/handheld_system_io_ports_core_assert.svh
// Assertion macros for the handheld system port block.
`ifndef HANDHELD_SYSTEM_IO_PORTS_CORE_ASSERT_SVH
`define HANDHELD_SYSTEM_IO_PORTS_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HSIO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HSIO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/hsio_pkg.sv
// Package with types, port constants and the power-on table of the system port block.
`default_nettype none
package hsio_pkg;
    localparam int PORT_COUNT   = 256;
    localparam int EEPROM_BYTES = 1024;
    localparam int EE_AW        = $clog2(EEPROM_BYTES);

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_EELOAD = 2'd2
    } state_t;

    localparam logic [7:0] P_SRC0  = 8'h4a;
    localparam logic [7:0] P_SRC1  = 8'h4b;
    localparam logic [7:0] P_SRC2  = 8'h4c;
    localparam logic [7:0] P_LEN0  = 8'h4e;
    localparam logic [7:0] P_LEN1  = 8'h4f;
    localparam logic [7:0] P_SCTL  = 8'h52;
    localparam logic [7:0] P_DISP6 = 8'h60;
    localparam logic [7:0] P_SNDLO = 8'h80;
    localparam logic [7:0] P_SNDDM = 8'h89;
    localparam logic [7:0] P_SNDHI = 8'h94;
    localparam logic [7:0] P_HWTYP = 8'ha0;
    localparam logic [7:0] P_VBASE = 8'hb0;
    localparam logic [7:0] P_SDAT  = 8'hb1;
    localparam logic [7:0] P_IEN   = 8'hb2;
    localparam logic [7:0] P_SCTRL = 8'hb3;
    localparam logic [7:0] P_KEYS  = 8'hb5;
    localparam logic [7:0] P_IPEND = 8'hb6;
    localparam logic [7:0] P_EEDLO = 8'hba;
    localparam logic [7:0] P_EEDHI = 8'hbb;
    localparam logic [7:0] P_EEALO = 8'hbc;
    localparam logic [7:0] P_EEAHI = 8'hbd;
    localparam logic [7:0] P_EECMD = 8'hbe;

    typedef struct packed {
        logic [7:0] vbase;
        logic [7:0] sdat;
        logic [7:0] ien;
        logic [7:0] ipend;
        logic [7:0] eeadr_lo;
        logic [7:0] eeadr_hi;
        logic [7:0] eedat_lo;
        logic [7:0] eedat_hi;
    } sysregs_t;

    function automatic logic [7:0] power_on(input logic [7:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (a >= 8'hc8) begin
            v = 8'hd1;
        end else begin
            case (a)
                8'h03: v = 8'hbb; 8'h07: v = 8'h26; 8'h08: v = 8'hfe; 8'h09: v = 8'hde;
                8'h0a: v = 8'hf9; 8'h0b: v = 8'hfb; 8'h0c: v = 8'hdb; 8'h0d: v = 8'hd7;
                8'h0e: v = 8'h7f; 8'h0f: v = 8'hf5; 8'h14: v = 8'h01; 8'h16: v = 8'h9e;
                8'h17: v = 8'h9b; 8'h1c: v = 8'h99; 8'h1d: v = 8'hfd; 8'h1e: v = 8'hb7;
                8'h1f: v = 8'hdf; 8'h20: v = 8'h30; 8'h21: v = 8'h57; 8'h22: v = 8'h75;
                8'h23: v = 8'h76; 8'h24: v = 8'h15; 8'h25: v = 8'h73; 8'h26: v = 8'h70;
                8'h27: v = 8'h77; 8'h28: v = 8'h20; 8'h29: v = 8'h75; 8'h2a: v = 8'h50;
                8'h2b: v = 8'h36; 8'h2c: v = 8'h70; 8'h2d: v = 8'h67; 8'h2e: v = 8'h50;
                8'h2f: v = 8'h77; 8'h30: v = 8'h57; 8'h31: v = 8'h54; 8'h32: v = 8'h75;
                8'h33: v = 8'h77; 8'h34: v = 8'h75; 8'h35: v = 8'h17; 8'h36: v = 8'h37;
                8'h37: v = 8'h73; 8'h38: v = 8'h50; 8'h39: v = 8'h57; 8'h3a: v = 8'h60;
                8'h3b: v = 8'h77; 8'h3c: v = 8'h70; 8'h3d: v = 8'h77; 8'h3e: v = 8'h10;
                8'h3f: v = 8'h73; 8'h60: v = 8'h0a; 8'h6b: v = 8'h0f; 8'h8d: v = 8'h1f;
                8'h9e: v = 8'h03; 8'ha0: v = 8'h87; 8'ha2: v = 8'h0c; 8'ha6: v = 8'h4f;
                8'ha7: v = 8'hff; 8'hb1: v = 8'hdb; 8'hb5: v = 8'h40; 8'hba: v = 8'h01;
                8'hbc: v = 8'h42; 8'hbe: v = 8'h83; 8'hc0: v = 8'h2f; 8'hc1: v = 8'h3f;
                8'hc2: v = 8'hff; 8'hc3: v = 8'hff;
                default: v = 8'h00;
            endcase
        end
        return v;
    endfunction
endpackage
`default_nettype wire

>>> design/hsio_port_ram.sv
// Generic port file memory with one write and one registered read port.
`default_nettype none
module hsio_port_ram #(
    parameter int AW = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/hsio_eeprom.sv
// Internal EEPROM word store, written and read one byte per cycle.
`default_nettype none
module hsio_eeprom
    import hsio_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [EE_AW-1:0] addr,
    input  wire logic [7:0]       wdata,
    output logic [7:0]            rdata
);
    logic [7:0] mem [EEPROM_BYTES];

    // The store is nonvolatile: it holds zeros at power-up and reset leaves it alone.
    initial begin
        for (int i = 0; i < EEPROM_BYTES; i++) begin
            mem[i] = 8'h00;
        end
    end

    always @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> design/handheld_system_io_ports_core.sv
// Top level of the handheld system port block.
`default_nettype none
// Each transaction is accepted into an item register and executed in the cycle
// after, since the port file memory has a registered read; no new one is
// taken until the last one is finished. EEPROM commands go on through the EELOAD
// state, one byte of the single-port EEPROM at a time. After reset a clearing
// pass loads the power-on table into the port file before the first item is
// accepted. The result is held in an output register, and a new transaction is
// accepted only while that register is empty or being read in the same cycle.
module handheld_system_io_ports_core
    import hsio_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode, addr, wdata, raise_mask, fetched_byte, cursor_y, cursor_x, buttons
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // rdata, irq_request, irq_vector, sound_write_valid, sound_write_addr,
    // sound_write_data, dma_address, bios_disabled
    output logic [55:0]      m_tdata
);
    state_t state_reg, state_next;
    logic [8:0] clr_reg;
    logic color_reg, rot_reg;
    logic [47:0] item_reg;
    sysregs_t sr_reg;
    logic [19:0] src_reg;
    logic [15:0] len_reg;
    logic [7:0] sctl_reg;
    logic boot_reg;
    logic out_v_reg;
    logic [55:0] out_reg;
    logic ee_phase_reg;
    logic [EE_AW-1:0] ee_base_reg;
    logic ee_cmd_wr_reg;

    logic [1:0] mode;
    logic [7:0] a, d, rmask, fb;
    logic [3:0] cy, cx, bt;
    logic pw_en;
    logic [7:0] pw_addr, pw_data, pr_addr, pr_data;
    logic ee_we;
    logic [EE_AW-1:0] ee_addr;
    logic [7:0] ee_wdata, ee_rdata;
    logic accept, clearing, out_free;

    assign mode  = item_reg[1:0];
    assign a     = item_reg[9:2];
    assign d     = item_reg[17:10];
    assign rmask = item_reg[25:18];
    assign fb    = item_reg[33:26];
    assign cy    = item_reg[37:34];
    assign cx    = item_reg[41:38];
    assign bt    = item_reg[45:42];

    assign clearing = !clr_reg[8];
    assign out_free = !out_v_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !clearing && out_free;
    assign accept   = s_tvalid && s_tready;
    assign pr_addr  = s_tdata[9:2];
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    hsio_port_ram #(.AW(8)) u_ports (
        .aclk(aclk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
        .raddr(pr_addr), .rdata(pr_data)
    );
    hsio_eeprom u_ee (
        .aclk(aclk), .we(ee_we), .addr(ee_addr), .wdata(ee_wdata), .rdata(ee_rdata)
    );

    function automatic logic [3:0] rotn(input logic [3:0] n);
        return {n[2:0], n[3]};
    endfunction

    logic disp, zero_rd, exec, do_tick;
    logic [7:0] rd, wv, pend, vec;
    logic [3:0] sel_lo;
    logic [2:0] hb;
    logic req, sv;
    logic [7:0] sa, sdd;
    logic [19:0] src_n;
    logic [15:0] len_n;
    logic [7:0] sctl_n;
    logic boot_n;
    logic [EE_AW-1:0] ee_base;
    logic [9:0] ee_full;
    logic ee_cmd_wr, ee_cmd_rd;
    sysregs_t sr_n;

    always_comb begin
        disp = (a < 8'h40) || (a >= 8'ha1 && a < P_VBASE);
        zero_rd = disp || a == P_DISP6 || (a >= 8'hc0 && a <= 8'hcf);
        exec = (state_reg == ST_EXEC);
        do_tick = (mode == MODE_TICK) && (sctl_reg[7] && !sctl_reg[3]);
        if (color_reg) begin
            ee_full = {sr_reg.eeadr_hi[0], sr_reg.eeadr_lo, 1'b0};
        end else begin
            ee_full = {3'b0, sr_reg.eeadr_lo[5:0], 1'b0};
        end
        ee_base = ee_full[EE_AW-1:0];
        ee_cmd_wr = (mode == MODE_WRITE) && a == P_EECMD && d[5];
        ee_cmd_rd = (mode == MODE_WRITE) && a == P_EECMD && !d[5] && d[4];

        rd = 8'h00;
        sel_lo = 4'h0;
        case (pr_data[7:4])
            4'h1: sel_lo = rot_reg ? rotn(cy) : cy;
            4'h2: sel_lo = rot_reg ? rotn(cx) : cx;
            4'h4: sel_lo = bt;
            default: sel_lo = 4'h0;
        endcase
        if (!zero_rd) begin
            case (a)
                P_SRC0: rd = src_reg[7:0];
                P_SRC1: rd = src_reg[15:8];
                P_SRC2: rd = {4'h0, src_reg[19:16]};
                P_LEN0: rd = len_reg[7:0];
                P_LEN1: rd = len_reg[15:8];
                P_SCTL: rd = sctl_reg;
                P_HWTYP: rd = (pr_data & 8'h7d) | {6'b0, color_reg, 1'b0} | 8'h80;
                P_SDAT: rd = sr_reg.sdat;
                P_KEYS: rd = {pr_data[7:4], sel_lo};
                default: rd = pr_data;
            endcase
        end

        sr_n = sr_reg; src_n = src_reg; len_n = len_reg; sctl_n = sctl_reg;
        boot_n = boot_reg; sv = 1'b0; sa = 8'h00; sdd = 8'h00;
        pw_en = 1'b0; pw_addr = a; wv = d;
        if (clearing) begin
            pw_en = 1'b1; pw_addr = clr_reg[7:0]; pw_data = power_on(clr_reg[7:0]);
        end else begin
            pw_data = d;
        end
        if (exec && !clearing) begin
            case (mode)
                MODE_WRITE: begin
                    if (!disp) begin
                        pw_en = 1'b1;
                        case (a)
                            P_SRC0: src_n[7:0] = d;
                            P_SRC1: src_n[15:8] = d;
                            P_SRC2: src_n[19:16] = d[3:0];
                            P_LEN0: len_n[7:0] = d;
                            P_LEN1: len_n[15:8] = d;
                            P_SCTL: sctl_n = d;
                            P_HWTYP: if (d[0]) boot_n = 1'b1;
                            P_SCTRL: begin
                                sr_n.sdat = 8'hff;
                                if (d[7]) wv = d | 8'h04;
                            end
                            P_IPEND: wv = sr_reg.ipend & ~d;
                            P_EECMD: begin
                                if (d[5]) wv = d | 8'h02;
                                else if (d[4]) wv = d | 8'h01;
                            end
                            default: begin
                                if (a >= P_SNDLO && a <= P_SNDHI) begin
                                    sv = 1'b1; sa = a; sdd = d;
                                end
                            end
                        endcase
                        pw_data = wv;
                        case (a)
                            P_VBASE: sr_n.vbase = wv;
                            P_SDAT:  sr_n.sdat = wv;
                            P_IEN:   sr_n.ien = wv;
                            P_IPEND: sr_n.ipend = wv;
                            P_EEALO: sr_n.eeadr_lo = wv;
                            P_EEAHI: sr_n.eeadr_hi = wv;
                            P_EEDLO: sr_n.eedat_lo = wv;
                            P_EEDHI: sr_n.eedat_hi = wv;
                            default: ;
                        endcase
                    end
                end
                MODE_RAISE: begin
                    sr_n.ipend = sr_reg.ipend | (rmask & sr_reg.ien);
                    pw_en = 1'b1; pw_addr = P_IPEND; pw_data = sr_n.ipend;
                end
                MODE_TICK: begin
                    if (do_tick) begin
                        sv = 1'b1; sa = P_SNDDM; sdd = fb;
                        pw_en = 1'b1; pw_addr = P_SNDDM; pw_data = fb;
                        len_n = len_reg - 16'd1;
                        src_n = src_reg + 20'd1;
                        if (len_n == 16'd0) sctl_n[7] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == ST_EELOAD && !ee_cmd_wr_reg) begin
            pw_en = 1'b1;
            pw_addr = ee_phase_reg ? P_EEDHI : P_EEDLO;
            pw_data = ee_rdata;
            if (ee_phase_reg) sr_n.eedat_hi = ee_rdata;
            else sr_n.eedat_lo = ee_rdata;
        end

        ee_we = 1'b0; ee_wdata = sr_reg.eedat_lo; ee_addr = ee_base;
        if (exec && ee_cmd_wr) begin
            ee_we = 1'b1;
        end else if (state_reg == ST_EELOAD) begin
            ee_addr = ee_base_reg + EE_AW'(1);
            if (!ee_phase_reg && ee_cmd_wr_reg) begin
                ee_we = 1'b1; ee_wdata = sr_reg.eedat_hi;
            end
        end

        pend = sr_n.ien & sr_n.ipend;
        req = |pend;
        hb = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (pend[i]) hb = 3'(i);
        end
        vec = req ? sr_n.vbase + {5'b0, hb} : 8'h00;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: begin
                if (ee_cmd_wr || ee_cmd_rd) state_next = ST_EELOAD;
                else if (out_free) state_next = ST_IDLE;
            end
            ST_EELOAD: if (ee_phase_reg && out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic [55:0] res_n;
    logic [55:0] res_reg;
    logic fin;

    assign fin = (exec && !(ee_cmd_wr || ee_cmd_rd) && out_free)
               || (state_reg == ST_EELOAD && ee_phase_reg && out_free);

    always_comb begin
        res_n = res_reg;
        if (exec) begin
            res_n = {1'b0, boot_n, src_n, sdd, sa, sv, vec, req,
                     (mode == MODE_READ) ? rd : 8'h00};
        end else if (state_reg == ST_EELOAD) begin
            res_n[16:9] = vec;
            res_n[8] = req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg <= 9'd0;
            color_reg <= 1'b0;
            rot_reg <= 1'b0;
            src_reg <= '0; len_reg <= '0; sctl_reg <= '0; boot_reg <= 1'b0;
            out_v_reg <= 1'b0;
            ee_phase_reg <= 1'b0;
            sr_reg <= '{vbase: 8'h00, sdat: 8'hdb, ien: 8'h00, ipend: 8'h00,
                        eeadr_lo: 8'h42, eeadr_hi: 8'h00, eedat_lo: 8'h01,
                        eedat_hi: 8'h00};
        end else begin
            if (clearing) clr_reg <= clr_reg + 9'd1;
            if (cfg_we) begin
                if (cfg_index) rot_reg <= cfg_wdata;
                else color_reg <= cfg_wdata;
            end
            state_reg <= state_next;
            sr_reg <= sr_n;
            if (exec) begin
                src_reg <= src_n; len_reg <= len_n; sctl_reg <= sctl_n; boot_reg <= boot_n;
            end
            if (fin) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
            if (state_reg == ST_EELOAD) ee_phase_reg <= !ee_phase_reg || !out_free;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) item_reg <= s_tdata;
        if (exec) begin
            ee_base_reg <= ee_base;
            ee_cmd_wr_reg <= ee_cmd_wr;
        end
        res_reg <= res_n;
        if (fin) out_reg <= res_n;
    end

    `include "handheld_system_io_ports_core_assert.svh"
    `HSIO_ASSERT_IMP(a_no_accept_clear, clearing, !s_tready)
    `HSIO_ASSERT_NEXT(a_accept_exec, accept, state_reg == ST_EXEC)
    `HSIO_ASSERT_IMP(a_irq_vec_zero, out_v_reg && !out_reg[8], out_reg[16:9] == 8'h00)
    `HSIO_ASSERT_IMP(a_busy_not_ready, state_reg != ST_IDLE, !s_tready)
endmodule
`default_nettype wire
